/* src/box_side_collision_accumulator_core_defines.svh */
// Assertion macros for the box side collision accumulator.
// Used by the top level only; clk and rst_n must be in scope where expanded.
`ifndef BOX_SIDE_COLLISION_ACCUMULATOR_CORE_DEFINES_SVH
`define BOX_SIDE_COLLISION_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BSCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define BSCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BSCA_ASSERT_NOW(label, ante, cons)
`define BSCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/bsca_pkg.sv */
// Shared types and constants for the box side collision accumulator.
// No dependencies; imported by every module of the block.
package bsca_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int COUNT_LIMIT_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int DIM_W   = 15;  // box width / height
  localparam int DEPTH_W = 16;  // overlap depth

  // side index order in flag vector and accumulators
  localparam int SIDE_R = 0;
  localparam int SIDE_L = 1;
  localparam int SIDE_D = 2;
  localparam int SIDE_U = 3;
  localparam int NUM_SIDES = 4;

  // classified word handed from front to back
  typedef struct packed {
    logic               h_hit;
    logic               h_is_left;
    logic [DEPTH_W-1:0] h_depth;
    logic               v_hit;
    logic               v_is_up;
    logic [DEPTH_W-1:0] v_depth;
    logic               tile;
    logic               last;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* src/bsca_front.sv */
// Front end: input register with edge sums, then side classification.
// Depends on bsca_pkg.
module bsca_front import bsca_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  input  logic        [DIM_W-1:0]      in_query_w,
  input  logic        [DIM_W-1:0]      in_query_h,
  input  logic signed [COORD_BITS-1:0] in_other_x,
  input  logic signed [COORD_BITS-1:0] in_other_y,
  input  logic        [DIM_W-1:0]      in_other_w,
  input  logic        [DIM_W-1:0]      in_other_h,
  input  logic                         in_is_self,
  input  logic                         in_is_tile,
  input  logic                         in_last_object,
  output logic                         push_valid,
  input  logic                         push_ready,
  output rec_t                         push_data
);

  localparam int SUM_BITS = ((COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1) + 1;

  typedef logic signed [SUM_BITS-1:0] sum_t;

  logic valid_r, valid_nxt;
  sum_t qx_r, qy_r, qr_r, qb_r, ox_r, oy_r, or_r, ob_r;
  logic skip_r, tile_r, last_r;

  sum_t qx, qy, ox, oy, qw, qh, ow, oh;
  logic accept;

  assign qx = {{(SUM_BITS-COORD_BITS){in_query_x[COORD_BITS-1]}}, in_query_x};
  assign qy = {{(SUM_BITS-COORD_BITS){in_query_y[COORD_BITS-1]}}, in_query_y};
  assign ox = {{(SUM_BITS-COORD_BITS){in_other_x[COORD_BITS-1]}}, in_other_x};
  assign oy = {{(SUM_BITS-COORD_BITS){in_other_y[COORD_BITS-1]}}, in_other_y};
  assign qw = {{(SUM_BITS-DIM_W){1'b0}}, in_query_w};
  assign qh = {{(SUM_BITS-DIM_W){1'b0}}, in_query_h};
  assign ow = {{(SUM_BITS-DIM_W){1'b0}}, in_other_w};
  assign oh = {{(SUM_BITS-DIM_W){1'b0}}, in_other_h};

  assign in_ready = !valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage 1: edges and skip decision
  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r   <= qx;
      qy_r   <= qy;
      qr_r   <= qx + qw;
      qb_r   <= qy + qh;
      ox_r   <= ox;
      oy_r   <= oy;
      or_r   <= ox + ow;
      ob_r   <= oy + oh;
      skip_r <= in_is_self || (in_other_w == '0 && in_other_h == '0);
      tile_r <= in_is_tile;
      last_r <= in_last_object;
    end
  end

  // stage 2 (comb): overlap tests; a depth is always below the query extent,
  // so the low 16 bits of the difference are exact
  logic x_over, y_over, r_hit, l_hit, d_hit, u_hit;
  sum_t r_dep, l_dep, d_dep, u_dep;

  always_comb begin
    y_over = (qy_r < ob_r) && (qb_r > oy_r);
    x_over = (qx_r < or_r) && (qr_r > ox_r);
    r_hit  = !skip_r && (qr_r > ox_r) && (qx_r < ox_r) && y_over;
    l_hit  = !skip_r && !r_hit && (qx_r < or_r) && (qr_r > or_r) && y_over;
    d_hit  = !skip_r && (qb_r > oy_r) && (qy_r < oy_r) && x_over;
    u_hit  = !skip_r && !d_hit && (qy_r < ob_r) && (qb_r > ob_r) && x_over;
    r_dep  = qr_r - ox_r;
    l_dep  = or_r - qx_r;
    d_dep  = qb_r - oy_r;
    u_dep  = ob_r - qy_r;

    push_data.h_hit     = r_hit || l_hit;
    push_data.h_is_left = l_hit;
    push_data.h_depth   = l_hit ? l_dep[DEPTH_W-1:0] : r_dep[DEPTH_W-1:0];
    push_data.v_hit     = d_hit || u_hit;
    push_data.v_is_up   = u_hit;
    push_data.v_depth   = u_hit ? u_dep[DEPTH_W-1:0] : d_dep[DEPTH_W-1:0];
    push_data.tile      = tile_r;
    push_data.last      = last_r;
  end

  assign push_valid = valid_r;

endmodule

/* src/bsca_queue.sv */
// Small FIFO of classified words between front and back.
// Depends on bsca_pkg.
module bsca_queue import bsca_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  rec_t        push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output rec_t        pop_data,
  output queue_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/bsca_back.sv */
// Back end: per-side accumulators, running max count and result register.
// Depends on bsca_pkg.
module bsca_back import bsca_pkg::*; #(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
  parameter int CNT_BITS    = $clog2(COUNT_LIMIT + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  rec_t                pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit_right,
  output logic                out_hit_left,
  output logic                out_hit_down,
  output logic                out_hit_up,
  output logic [DEPTH_W-1:0]  out_depth_right,
  output logic [DEPTH_W-1:0]  out_depth_left,
  output logic [DEPTH_W-1:0]  out_depth_down,
  output logic [DEPTH_W-1:0]  out_depth_up,
  output logic [CNT_BITS-1:0] out_max_side_count
);

  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [DEPTH_W-1:0]  dep_t;

  logic [NUM_SIDES-1:0] flags_r, flags_nxt, flags_upd;
  dep_t                 dep_r [NUM_SIDES];
  dep_t                 dep_nxt [NUM_SIDES];
  dep_t                 dep_upd [NUM_SIDES];
  cnt_t                 cnt_r [NUM_SIDES];
  cnt_t                 cnt_nxt [NUM_SIDES];
  cnt_t                 cnt_upd [NUM_SIDES];
  cnt_t                 rmax_r, rmax_nxt, rmax_upd, rmax_h;
  logic                 out_valid_r, out_valid_nxt;
  logic [NUM_SIDES-1:0] out_flags_r;
  dep_t                 out_dep_r [NUM_SIDES];
  cnt_t                 out_max_r;

  cnt_t h_cnt, v_cnt, h_inc, v_inc;
  dep_t h_dep, v_dep;
  logic pop, emit;

  function automatic cnt_t sat_inc(cnt_t c);
    return (c < cnt_t'(COUNT_LIMIT)) ? c + 1'b1 : c;
  endfunction

  // a last word waits only while an earlier result is still unread
  assign pop_ready = !pop_data.last || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;
  assign emit      = pop && pop_data.last;

  always_comb begin
    h_cnt = pop_data.h_is_left ? cnt_r[SIDE_L] : cnt_r[SIDE_R];
    v_cnt = pop_data.v_is_up   ? cnt_r[SIDE_U] : cnt_r[SIDE_D];
    h_dep = pop_data.h_is_left ? dep_r[SIDE_L] : dep_r[SIDE_R];
    v_dep = pop_data.v_is_up   ? dep_r[SIDE_U] : dep_r[SIDE_D];
    h_inc = sat_inc(h_cnt);
    v_inc = sat_inc(v_cnt);

    flags_upd = flags_r;
    cnt_upd   = cnt_r;
    dep_upd   = dep_r;
    if (pop_data.h_hit) begin
      if (pop_data.h_is_left) begin
        flags_upd[SIDE_L] = 1'b1;
        cnt_upd[SIDE_L]   = h_inc;
        if (pop_data.h_depth > h_dep) dep_upd[SIDE_L] = pop_data.h_depth;
      end else begin
        flags_upd[SIDE_R] = 1'b1;
        cnt_upd[SIDE_R]   = h_inc;
        if (pop_data.h_depth > h_dep) dep_upd[SIDE_R] = pop_data.h_depth;
      end
    end
    if (pop_data.v_hit) begin
      if (pop_data.v_is_up) begin
        flags_upd[SIDE_U] = 1'b1;
        cnt_upd[SIDE_U]   = v_inc;
        if (pop_data.v_depth > v_dep) dep_upd[SIDE_U] = pop_data.v_depth;
      end else begin
        flags_upd[SIDE_D] = 1'b1;
        cnt_upd[SIDE_D]   = v_inc;
        if (pop_data.v_depth > v_dep) dep_upd[SIDE_D] = pop_data.v_depth;
      end
    end

    // horizontal hit updates the max first, then vertical
    rmax_h   = (pop_data.h_hit && !pop_data.tile && h_inc > rmax_r) ? h_inc : rmax_r;
    rmax_upd = (pop_data.v_hit && !pop_data.tile && v_inc > rmax_h) ? v_inc : rmax_h;

    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    dep_nxt   = dep_r;
    rmax_nxt  = rmax_r;
    if (pop) begin
      if (pop_data.last) begin
        flags_nxt = '0;
        rmax_nxt  = '0;
        for (int i = 0; i < NUM_SIDES; i++) begin
          cnt_nxt[i] = '0;
          dep_nxt[i] = '0;
        end
      end else begin
        flags_nxt = flags_upd;
        cnt_nxt   = cnt_upd;
        dep_nxt   = dep_upd;
        rmax_nxt  = rmax_upd;
      end
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      rmax_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SIDES; i++) begin
        cnt_r[i] <= '0;
        dep_r[i] <= '0;
      end
    end else begin
      flags_r     <= flags_nxt;
      rmax_r      <= rmax_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      dep_r       <= dep_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (emit) begin
      out_flags_r <= flags_upd;
      out_dep_r   <= dep_upd;
      out_max_r   <= rmax_upd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit_right      = out_flags_r[SIDE_R];
  assign out_hit_left       = out_flags_r[SIDE_L];
  assign out_hit_down       = out_flags_r[SIDE_D];
  assign out_hit_up         = out_flags_r[SIDE_U];
  assign out_depth_right    = out_dep_r[SIDE_R];
  assign out_depth_left     = out_dep_r[SIDE_L];
  assign out_depth_down     = out_dep_r[SIDE_D];
  assign out_depth_up       = out_dep_r[SIDE_U];
  assign out_max_side_count = out_max_r;

endmodule

/* src/box_side_collision_accumulator_core.sv */
// Top level of the box side collision accumulator.
// Depends on bsca_pkg, bsca_front, bsca_queue, bsca_back and the defines header.
//
//   channel | handshake            | word
//   --------+----------------------+-------------------------------------------
//   in_     | in_valid / in_ready  | query box, scene box, self/tile/last flags
//   out_    | out_valid / out_ready| side hit flags, side depths, max count
//
// Rate: one word per clock sustained while the queue is not full. The last word
//   goes from front register via queue write to result register, then out_valid rises.
// Reset: synchronous, active low; clears queue, accumulators and valids. No sweep.
// Stalls: the queue lets the front keep taking words while the back waits on an
//   unread result; only a last word blocks behind a pending result.

`include "box_side_collision_accumulator_core_defines.svh"

module box_side_collision_accumulator_core import bsca_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CNT_BITS    = $clog2(COUNT_LIMIT + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  input  logic        [DIM_W-1:0]      in_query_w,
  input  logic        [DIM_W-1:0]      in_query_h,
  input  logic signed [COORD_BITS-1:0] in_other_x,
  input  logic signed [COORD_BITS-1:0] in_other_y,
  input  logic        [DIM_W-1:0]      in_other_w,
  input  logic        [DIM_W-1:0]      in_other_h,
  input  logic                         in_is_self,
  input  logic                         in_is_tile,
  input  logic                         in_last_object,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit_right,
  output logic                         out_hit_left,
  output logic                         out_hit_down,
  output logic                         out_hit_up,
  output logic [DEPTH_W-1:0]           out_depth_right,
  output logic [DEPTH_W-1:0]           out_depth_left,
  output logic [DEPTH_W-1:0]           out_depth_down,
  output logic [DEPTH_W-1:0]           out_depth_up,
  output logic [CNT_BITS-1:0]          out_max_side_count
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  rec_t        push_data, pop_data;
  queue_stat_t q_stat;

  // front: register edges, classify each word into at most one horizontal
  // and one vertical side hit
  bsca_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .in_query_w     (in_query_w),
    .in_query_h     (in_query_h),
    .in_other_x     (in_other_x),
    .in_other_y     (in_other_y),
    .in_other_w     (in_other_w),
    .in_other_h     (in_other_h),
    .in_is_self     (in_is_self),
    .in_is_tile     (in_is_tile),
    .in_last_object (in_last_object),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  bsca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .stat       (q_stat)
  );

  // back: accumulate per side, emit and clear on a last word
  bsca_back #(
    .COUNT_LIMIT (COUNT_LIMIT),
    .CNT_BITS    (CNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_data           (pop_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit_right      (out_hit_right),
    .out_hit_left       (out_hit_left),
    .out_hit_down       (out_hit_down),
    .out_hit_up         (out_hit_up),
    .out_depth_right    (out_depth_right),
    .out_depth_left     (out_depth_left),
    .out_depth_down     (out_depth_down),
    .out_depth_up       (out_depth_up),
    .out_max_side_count (out_max_side_count)
  );

  // queue never reports full and empty together
  `BSCA_ASSERT_NOW(a_queue_stat, 1'b1, !(q_stat.full && q_stat.empty))
  // input backpressure only comes from a full queue behind a loaded front stage
  `BSCA_ASSERT_NOW(a_in_stall, !in_ready, push_valid && !push_ready && q_stat.full)
  // back stalls only on a last word while a result is unread
  `BSCA_ASSERT_NOW(a_back_stall, pop_valid && !pop_ready, pop_data.last && out_valid && !out_ready)
  // a popped last word always produces a result
  `BSCA_ASSERT_NEXT(a_emit, pop_valid && pop_ready && pop_data.last, out_valid)

endmodule
